### src/joint_intensity_histogram_unit_macros.svh
// assertion helpers for the joint histogram unit
`ifndef JOINT_INTENSITY_HISTOGRAM_UNIT_MACROS_SVH
`define JOINT_INTENSITY_HISTOGRAM_UNIT_MACROS_SVH

// same-cycle implication
`define JIH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("joint histogram check failed");

// next-cycle implication
`define JIH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("joint histogram check failed");

`endif

### src/jih_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jih_pkg;

   localparam int unsigned COUNT_W      = 26;
   localparam int unsigned POS_W        = 13;
   localparam int unsigned CSR_DATA_W   = 13;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned OP_ADDR_W    = 16;
   localparam int unsigned PIXEL_W      = 8;
   localparam int unsigned READ_INDEX_W = 12;
   localparam int unsigned DIVISOR_W    = 8;
   localparam int unsigned LOG2_W       = 3;
   localparam int unsigned SHIFT_W      = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
   localparam logic [POS_W-1:0]   POS_MAX       = '1;
   localparam logic [COUNT_W:0]   BIN_INCREMENT = (COUNT_W + 1)'(2);

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_PIXEL  = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INC    = 2'd1,
      OP_DIVIDE = 2'd2,
      OP_READ   = 2'd3
   } op_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BINS_LOG2   = 3'd0,
      REG_BG_WEIGHT   = 3'd1,
      REG_IMG_WIDTH   = 3'd2,
      REG_IMG_HEIGHT  = 3'd3,
      REG_WIN_START_X = 3'd4,
      REG_WIN_END_X   = 3'd5,
      REG_WIN_START_Y = 3'd6,
      REG_WIN_END_Y   = 3'd7
   } reg_index_type;

   typedef struct packed {
      op_kind_type            kind;
      logic [OP_ADDR_W-1:0]   addr;
   } op_type;

   typedef struct packed {
      logic [LOG2_W-1:0]      bins_log2;
      logic [DIVISOR_W-1:0]   bg_weight;
      logic [POS_W-1:0]       img_width;
      logic [POS_W-1:0]       img_height;
      logic [POS_W-1:0]       win_start_x;
      logic [POS_W-1:0]       win_end_x;
      logic [POS_W-1:0]       win_start_y;
      logic [POS_W-1:0]       win_end_y;
   } cfg_type;

   // bins per axis exponent, clipped to the store size
   function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] cfg_log2,
                                                  input int unsigned max_log2);
      logic [LOG2_W-1:0] result;
      result = cfg_log2;
      if (32'(cfg_log2) > max_log2) begin
         result = LOG2_W'(max_log2);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

### src/jih_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jih_front #(
   parameter int unsigned MAX_BINS_LOG2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  jih_pkg::cfg_type                    cfg,
   input  logic                                push,
   output logic                                full,
   input  logic [1:0]                          req_cmd,
   input  logic [jih_pkg::PIXEL_W-1:0]         req_target_pixel,
   input  logic [jih_pkg::PIXEL_W-1:0]         req_render_pixel,
   input  logic [jih_pkg::READ_INDEX_W-1:0]    req_bin_index,
   input  logic                                clearing,
   input  logic                                op_full,
   output logic                                op_push,
   output jih_pkg::op_type                     op_out
);

   logic                               accept;
   logic [jih_pkg::LOG2_W-1:0]         eff;
   logic [jih_pkg::SHIFT_W-1:0]        shift;
   logic [jih_pkg::PIXEL_W-1:0]        t_bin;
   logic [jih_pkg::PIXEL_W-1:0]        r_bin;
   logic [jih_pkg::POS_W-1:0]          end_x;
   logic [jih_pkg::POS_W-1:0]          end_y;
   logic                               in_window;
   logic [jih_pkg::POS_W:0]            col_next;
   logic [jih_pkg::POS_W-1:0]          col_ff, col_in;
   logic [jih_pkg::POS_W-1:0]          row_ff, row_in;

   assign full   = op_full | clearing;
   assign accept = push & ~full;

   always_comb begin
      eff       = jih_pkg::eff_log2(cfg.bins_log2, MAX_BINS_LOG2);
      shift     = jih_pkg::SHIFT_W'(jih_pkg::PIXEL_W) - {1'b0, eff};
      t_bin     = req_target_pixel >> shift;
      r_bin     = req_render_pixel >> shift;
      end_x     = (cfg.win_end_x == '0) ? cfg.img_width : cfg.win_end_x;
      end_y     = (cfg.win_end_y == '0) ? cfg.img_height : cfg.win_end_y;
      in_window = (col_ff >= cfg.win_start_x) && (col_ff < end_x) &&
                  (row_ff >= cfg.win_start_y) && (row_ff < end_y);
      col_next  = {1'b0, col_ff} + (jih_pkg::POS_W + 1)'(1);

      col_in       = col_ff;
      row_in       = row_ff;
      op_push      = 1'b0;
      op_out.kind  = jih_pkg::OP_READ;
      op_out.addr  = jih_pkg::OP_ADDR_W'(req_bin_index);

      if (accept) begin
         case (jih_pkg::cmd_type'(req_cmd))
            jih_pkg::CMD_START: begin
               col_in      = '0;
               row_in      = '0;
               op_push     = 1'b1;
               op_out.kind = jih_pkg::OP_CLEAR;
            end
            jih_pkg::CMD_PIXEL: begin
               op_push     = in_window;
               op_out.kind = jih_pkg::OP_INC;
               op_out.addr = jih_pkg::OP_ADDR_W'(t_bin) +
                             (jih_pkg::OP_ADDR_W'(r_bin) << eff);
               if (col_next >= {1'b0, cfg.img_width}) begin
                  col_in = '0;
                  if (row_ff != jih_pkg::POS_MAX) begin
                     row_in = row_ff + jih_pkg::POS_W'(1);
                  end
               end else begin
                  col_in = col_next[jih_pkg::POS_W-1:0];
               end
            end
            jih_pkg::CMD_FINISH: begin
               op_push     = 1'b1;
               op_out.kind = jih_pkg::OP_DIVIDE;
            end
            jih_pkg::CMD_READ: begin
               op_push     = 1'b1;
               op_out.kind = jih_pkg::OP_READ;
            end
            default: begin
               op_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

### src/jih_opq.sv
`timescale 1ns / 1ps
`default_nettype none

module jih_opq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jih_pkg::op_type   op_in,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output jih_pkg::op_type   head
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   jih_pkg::op_type     entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in;
   logic [PTR_W-1:0]    rd_ff, rd_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = entry_ff[rd_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ff] <= op_in;
      end
   end

endmodule

`default_nettype wire

### src/jih_div.sv
`timescale 1ns / 1ps
`default_nettype none

module jih_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [jih_pkg::COUNT_W-1:0]       dividend,
   input  logic [jih_pkg::DIVISOR_W-1:0]     divisor,
   output logic                              done,
   output logic [jih_pkg::COUNT_W-1:0]       quotient
);

   localparam int unsigned STEP_W = $clog2(jih_pkg::COUNT_W);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic [jih_pkg::DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [jih_pkg::DIVISOR_W-1:0]     div_ff, div_in;
   logic [jih_pkg::COUNT_W-1:0]       quo_ff, quo_in;
   logic [jih_pkg::DIVISOR_W:0]       trial;
   logic                              fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[jih_pkg::COUNT_W-1]};
      fits    = (trial >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? jih_pkg::DIVISOR_W'(trial - {1'b0, div_ff})
                        : trial[jih_pkg::DIVISOR_W-1:0];
         quo_in  = {quo_ff[jih_pkg::COUNT_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(jih_pkg::COUNT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
   end

endmodule

`default_nettype wire

### src/jih_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jih_back #(
   parameter int unsigned MAX_BINS_LOG2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  jih_pkg::cfg_type                  cfg,
   input  logic                              op_valid,
   input  jih_pkg::op_type                   op_head,
   output logic                              op_pop,
   output logic                              clearing,
   output logic                              empty,
   input  logic                              pop,
   output logic [jih_pkg::COUNT_W-1:0]       rsp_bin_count
);

   localparam int unsigned AW       = 2 * MAX_BINS_LOG2;
   localparam int unsigned DEPTH    = 1 << AW;
   localparam int unsigned RQ_DEPTH = 4;
   localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DIV_READ,
      ST_DIV_LOAD,
      ST_DIV_WAIT
   } state_type;

   state_type                        state_ff, state_in;
   logic [AW-1:0]                    sweep_ff, sweep_in;
   logic                             s1_valid_ff, s1_valid_in;
   logic                             s1_read_ff, s1_read_in;
   logic [AW-1:0]                    s1_addr_ff, s1_addr_in;
   logic                             last_valid_ff, last_valid_in;
   logic [AW-1:0]                    last_addr_ff, last_addr_in;
   logic [jih_pkg::COUNT_W-1:0]      last_data_ff, last_data_in;

   logic [jih_pkg::COUNT_W-1:0]      bin_mem [DEPTH];
   logic [jih_pkg::COUNT_W-1:0]      rd_data_ff;
   logic [AW-1:0]                    rd_addr;
   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [jih_pkg::COUNT_W-1:0]      wr_data;

   logic [AW-1:0]                    fwd_addr;
   logic [jih_pkg::COUNT_W-1:0]      cur;
   logic [jih_pkg::COUNT_W:0]        sum;
   logic [jih_pkg::LOG2_W-1:0]       eff;
   logic [AW-1:0]                    last_bin;
   logic                             advance;

   logic [jih_pkg::COUNT_W-1:0]      rq_entry_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]              rq_wr_ff, rq_wr_in;
   logic [RQ_PTR_W-1:0]              rq_rd_ff, rq_rd_in;
   logic [RQ_CNT_W-1:0]              rq_cnt_ff, rq_cnt_in;
   logic                             rq_push;
   logic                             rq_pop;
   logic                             can_read;

   logic                             div_start;
   logic                             div_done;
   logic [jih_pkg::COUNT_W-1:0]      div_quotient;

   jih_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cur),
      .divisor  (cfg.bg_weight),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign clearing      = (state_ff == ST_CLEAR);
   assign empty         = (rq_cnt_ff == '0);
   assign rsp_bin_count = rq_entry_ff[rq_rd_ff];
   assign rq_pop        = pop & ~empty;

   always_comb begin
      eff      = jih_pkg::eff_log2(cfg.bins_log2, MAX_BINS_LOG2);
      last_bin = AW'((jih_pkg::OP_ADDR_W'(1) << eff) - jih_pkg::OP_ADDR_W'(1));
      fwd_addr = (state_ff == ST_RUN) ? s1_addr_ff : sweep_ff;
      cur      = (last_valid_ff && (last_addr_ff == fwd_addr)) ? last_data_ff : rd_data_ff;
      sum      = {1'b0, cur} + jih_pkg::BIN_INCREMENT;
      can_read = (rq_cnt_ff + RQ_CNT_W'(s1_valid_ff & s1_read_ff)) < RQ_CNT_W'(RQ_DEPTH);

      state_in    = state_ff;
      sweep_in    = sweep_ff;
      s1_valid_in = 1'b0;
      s1_read_in  = s1_read_ff;
      s1_addr_in  = s1_addr_ff;
      op_pop      = 1'b0;
      rd_addr     = op_head.addr[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = s1_addr_ff;
      wr_data     = '0;
      rq_push     = 1'b0;
      div_start   = 1'b0;
      advance     = 1'b0;

      // second stage of the increment and read path
      if (s1_valid_ff) begin
         if (s1_read_ff) begin
            rq_push = 1'b1;
         end else begin
            wr_en   = 1'b1;
            wr_data = sum[jih_pkg::COUNT_W] ? jih_pkg::COUNT_MAX
                                            : sum[jih_pkg::COUNT_W-1:0];
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = '0;
            if (sweep_ff == '1) begin
               state_in = ST_RUN;
               sweep_in = '0;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ST_RUN: begin
            if (op_valid) begin
               case (op_head.kind)
                  jih_pkg::OP_INC: begin
                     op_pop      = 1'b1;
                     s1_valid_in = 1'b1;
                     s1_read_in  = 1'b0;
                     s1_addr_in  = op_head.addr[AW-1:0];
                  end
                  jih_pkg::OP_READ: begin
                     if (can_read) begin
                        op_pop      = 1'b1;
                        s1_valid_in = 1'b1;
                        s1_read_in  = 1'b1;
                        s1_addr_in  = op_head.addr[AW-1:0];
                     end
                  end
                  jih_pkg::OP_CLEAR: begin
                     if (!s1_valid_ff) begin
                        op_pop   = 1'b1;
                        state_in = ST_CLEAR;
                        sweep_in = '0;
                     end
                  end
                  jih_pkg::OP_DIVIDE: begin
                     if (!s1_valid_ff) begin
                        op_pop   = 1'b1;
                        state_in = ST_DIV_READ;
                        sweep_in = '0;
                     end
                  end
                  default: begin
                     op_pop = 1'b0;
                  end
               endcase
            end
         end
         ST_DIV_READ: begin
            rd_addr  = sweep_ff;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            if (cfg.bg_weight == '0) begin
               wr_en   = 1'b1;
               wr_addr = sweep_ff;
               wr_data = '0;
               advance = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               wr_en   = 1'b1;
               wr_addr = sweep_ff;
               wr_data = div_quotient;
               advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      if (advance) begin
         if (sweep_ff == last_bin) begin
            state_in = ST_RUN;
            sweep_in = '0;
         end else begin
            state_in = ST_DIV_READ;
            sweep_in = sweep_ff + AW'(1);
         end
      end

      last_valid_in = last_valid_ff;
      last_addr_in  = last_addr_ff;
      last_data_in  = last_data_ff;
      if (wr_en) begin
         last_valid_in = 1'b1;
         last_addr_in  = wr_addr;
         last_data_in  = wr_data;
      end

      rq_wr_in  = rq_push ? rq_wr_ff + RQ_PTR_W'(1) : rq_wr_ff;
      rq_rd_in  = rq_pop ? rq_rd_ff + RQ_PTR_W'(1) : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff + RQ_CNT_W'(rq_push) - RQ_CNT_W'(rq_pop);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= bin_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         last_valid_ff <= 1'b0;
         rq_wr_ff      <= '0;
         rq_rd_ff      <= '0;
         rq_cnt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         s1_valid_ff   <= s1_valid_in;
         last_valid_ff <= last_valid_in;
         rq_wr_ff      <= rq_wr_in;
         rq_rd_ff      <= rq_rd_in;
         rq_cnt_ff     <= rq_cnt_in;
      end
      s1_read_ff   <= s1_read_in;
      s1_addr_ff   <= s1_addr_in;
      last_addr_ff <= last_addr_in;
      last_data_ff <= last_data_in;
      if (rq_push) begin
         rq_entry_ff[rq_wr_ff] <= cur;
      end
   end

endmodule

`default_nettype wire

### src/joint_intensity_histogram_unit.sv
// joint intensity histogram of two 8-bit images
// request channel: push/full carries cmd (start, pixel pair, finish, read) with the
// target and render pixels or a bin index; a request is taken when push is high
// and full is low. pixel pairs are taken one per cycle while full stays low.
// result channel: empty/pop; only a read gives a result, shown on rsp_bin_count
// while empty is low and removed when pop is high. four results can wait; when
// the receiver stalls, reads stop in the back end and the request queue fills,
// which raises full.
// a read passes through the op queue, the bin read stage and the result queue.
// start clears all 2^(2*MAX_BINS_LOG2) bins (4096 by default) in a sweep, one
// bin per cycle through the single write port.
// finish divides each background bin by bg_weight in the 26-step divider, or
// writes zero to each background bin when the weight is zero.
// reset runs the same clearing sweep; full stays high until it ends, and the
// position counters and registers take their reset values at once.
// configuration: valid/ready with csr_index and csr_data, written while idle;
// ready is always high.
`timescale 1ns / 1ps
`default_nettype none

`include "joint_intensity_histogram_unit_macros.svh"

module joint_intensity_histogram_unit #(
   parameter int unsigned MAX_BINS_LOG2 = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [1:0]                          req_cmd,
   input  logic [jih_pkg::PIXEL_W-1:0]         req_target_pixel,
   input  logic [jih_pkg::PIXEL_W-1:0]         req_render_pixel,
   input  logic [jih_pkg::READ_INDEX_W-1:0]    req_bin_index,
   output logic                                empty,
   input  logic                                pop,
   output logic [jih_pkg::COUNT_W-1:0]         rsp_bin_count,
   input  logic                                valid,
   output logic                                ready,
   input  logic [jih_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [jih_pkg::CSR_DATA_W-1:0]      csr_data
);

   jih_pkg::cfg_type    cfg_ff, cfg_in;
   logic                clearing;
   logic                op_push;
   logic                op_full;
   logic                op_pop;
   logic                op_empty;
   jih_pkg::op_type     op_new;
   jih_pkg::op_type     op_head;

   assign ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid && ready) begin
         case (jih_pkg::reg_index_type'(csr_index))
            jih_pkg::REG_BINS_LOG2:   cfg_in.bins_log2   = csr_data[jih_pkg::LOG2_W-1:0];
            jih_pkg::REG_BG_WEIGHT:   cfg_in.bg_weight   = csr_data[jih_pkg::DIVISOR_W-1:0];
            jih_pkg::REG_IMG_WIDTH:   cfg_in.img_width   = csr_data;
            jih_pkg::REG_IMG_HEIGHT:  cfg_in.img_height  = csr_data;
            jih_pkg::REG_WIN_START_X: cfg_in.win_start_x = csr_data;
            jih_pkg::REG_WIN_END_X:   cfg_in.win_end_x   = csr_data;
            jih_pkg::REG_WIN_START_Y: cfg_in.win_start_y = csr_data;
            jih_pkg::REG_WIN_END_Y:   cfg_in.win_end_y   = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bins_log2   <= jih_pkg::LOG2_W'(5);
         cfg_ff.bg_weight   <= jih_pkg::DIVISOR_W'(1);
         cfg_ff.img_width   <= jih_pkg::POS_W'(640);
         cfg_ff.img_height  <= jih_pkg::POS_W'(480);
         cfg_ff.win_start_x <= '0;
         cfg_ff.win_end_x   <= '0;
         cfg_ff.win_start_y <= '0;
         cfg_ff.win_end_y   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jih_front #(
      .MAX_BINS_LOG2 (MAX_BINS_LOG2)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_target_pixel (req_target_pixel),
      .req_render_pixel (req_render_pixel),
      .req_bin_index    (req_bin_index),
      .clearing         (clearing),
      .op_full          (op_full),
      .op_push          (op_push),
      .op_out           (op_new)
   );

   jih_opq u_opq (
      .clock (clock),
      .reset (reset),
      .push  (op_push),
      .op_in (op_new),
      .full  (op_full),
      .pop   (op_pop),
      .empty (op_empty),
      .head  (op_head)
   );

   jih_back #(
      .MAX_BINS_LOG2 (MAX_BINS_LOG2)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .op_valid      (~op_empty),
      .op_head       (op_head),
      .op_pop        (op_pop),
      .clearing      (clearing),
      .empty         (empty),
      .pop           (pop),
      .rsp_bin_count (rsp_bin_count)
   );

   `JIH_ASSERT_NOW(a_full_after_reset, clock, reset, $past(reset), full)
   `JIH_ASSERT_NOW(a_no_push_when_op_full, clock, reset, op_push, !op_full)
   `JIH_ASSERT_NOW(a_clear_from_start, clock, reset, $rose(clearing), $past(op_pop))
   `JIH_ASSERT_NEXT(a_pop_from_queue, clock, reset, op_pop, $past(!op_empty))

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   import jih_pkg::*;

   localparam int unsigned AXIS_LOG2_MAX = 6;
   localparam int unsigned STORE_BINS    = 1 << (2 * AXIS_LOG2_MAX);
   localparam int unsigned SWEEP_PHASE   = 4;
   localparam int unsigned SWEEP_PIXELS  = 60;
   localparam int unsigned PHASE_ITEMS   = 95;

   typedef struct {
      cmd_type                   cmd;
      logic [PIXEL_W-1:0]        target;
      logic [PIXEL_W-1:0]        render;
      logic [READ_INDEX_W-1:0]   index;
      bit                        known;
      logic [COUNT_W-1:0]        count;
   } hist_req_type;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       push             = 1'b0;
   logic                       full;
   logic [1:0]                 req_cmd          = CMD_START;
   logic [PIXEL_W-1:0]         req_target_pixel = '0;
   logic [PIXEL_W-1:0]         req_render_pixel = '0;
   logic [READ_INDEX_W-1:0]    req_bin_index    = '0;
   logic                       empty;
   logic                       pop              = 1'b0;
   logic [COUNT_W-1:0]         rsp_bin_count;
   logic                       valid            = 1'b0;
   logic                       ready;
   logic [CSR_INDEX_W-1:0]     csr_index        = REG_BINS_LOG2;
   logic [CSR_DATA_W-1:0]      csr_data         = '0;

   // predicted histogram state
   logic [COUNT_W-1:0]         model_bins [STORE_BINS];
   logic [POS_W-1:0]           model_col;
   logic [POS_W-1:0]           model_row;
   cfg_type                    model_cfg;
   int unsigned                last_bin = 0;

   logic [COUNT_W-1:0]         pending_counts [$];
   hist_req_type               directed_rows [$];
   int                         mismatch_count = 0;
   int                         burst_left     = 0;
   int                         max_gap        = 3;

   joint_intensity_histogram_unit #(
      .MAX_BINS_LOG2(AXIS_LOG2_MAX)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_target_pixel (req_target_pixel),
      .req_render_pixel (req_render_pixel),
      .req_bin_index    (req_bin_index),
      .empty            (empty),
      .pop              (pop),
      .rsp_bin_count    (rsp_bin_count),
      .valid            (valid),
      .ready            (ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                  input logic [COUNT_W-1:0] want);
      $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic int unsigned axis_log2();
      return (model_cfg.bins_log2 > AXIS_LOG2_MAX) ? AXIS_LOG2_MAX : model_cfg.bins_log2;
   endfunction

   task automatic histogram_reset();
      foreach (model_bins[i]) model_bins[i] = '0;
      model_col = '0;
      model_row = '0;
      model_cfg = '{bins_log2: 3'd5, bg_weight: 8'd1, img_width: 13'd640,
                    img_height: 13'd480, win_start_x: '0, win_end_x: '0,
                    win_start_y: '0, win_end_y: '0};
   endtask

   task automatic histogram_config(input reg_index_type idx, input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_BINS_LOG2:   model_cfg.bins_log2   = data[LOG2_W-1:0];
         REG_BG_WEIGHT:   model_cfg.bg_weight   = data[DIVISOR_W-1:0];
         REG_IMG_WIDTH:   model_cfg.img_width   = data;
         REG_IMG_HEIGHT:  model_cfg.img_height  = data;
         REG_WIN_START_X: model_cfg.win_start_x = data;
         REG_WIN_END_X:   model_cfg.win_end_x   = data;
         REG_WIN_START_Y: model_cfg.win_start_y = data;
         REG_WIN_END_Y:   model_cfg.win_end_y   = data;
         default: ;
      endcase
   endtask

   task automatic histogram_step(input hist_req_type rq, output bit gives,
                                 output logic [COUNT_W-1:0] cnt);
      int unsigned b, k, bin, ex, ey, next_col;
      logic [COUNT_W:0] sum;
      gives = 1'b0;
      cnt = '0;
      b = axis_log2();
      k = 8 - b;
      case (rq.cmd)
         CMD_START: begin
            foreach (model_bins[i]) model_bins[i] = '0;
            model_col = '0;
            model_row = '0;
         end
         CMD_PIXEL: begin
            ex = (model_cfg.win_end_x != 0) ? model_cfg.win_end_x : model_cfg.img_width;
            ey = (model_cfg.win_end_y != 0) ? model_cfg.win_end_y : model_cfg.img_height;
            if (model_col >= model_cfg.win_start_x && model_col < ex &&
                model_row >= model_cfg.win_start_y && model_row < ey) begin
               bin = ((32'(rq.target) >> k) + ((32'(rq.render) >> k) << b)) & (STORE_BINS - 1);
               sum = {1'b0, model_bins[bin]} + BIN_INCREMENT;
               model_bins[bin] = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
               last_bin = bin;
            end
            next_col = model_col + 1;
            if (next_col >= model_cfg.img_width) begin
               model_col = '0;
               if (model_row != POS_MAX) model_row = model_row + 1'b1;
            end else begin
               model_col = next_col[POS_W-1:0];
            end
         end
         CMD_FINISH: begin
            for (int i = 0; i < (1 << b); i++) begin
               model_bins[i] = (model_cfg.bg_weight != 0) ?
                               model_bins[i] / model_cfg.bg_weight : '0;
            end
         end
         default: begin
            gives = 1'b1;
            cnt = model_bins[rq.index];
         end
      endcase
   endtask

   function automatic hist_req_type make_row(input cmd_type cmd, input logic [PIXEL_W-1:0] t,
                                             input logic [PIXEL_W-1:0] r,
                                             input logic [READ_INDEX_W-1:0] idx,
                                             input bit known, input logic [COUNT_W-1:0] cnt);
      hist_req_type rq;
      rq.cmd = cmd;
      rq.target = t;
      rq.render = r;
      rq.index = idx;
      rq.known = known;
      rq.count = cnt;
      return rq;
   endfunction

   function automatic logic [PIXEL_W-1:0] pixel_value();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return PIXEL_W'($urandom);
   endfunction

   function automatic hist_req_type random_request();
      hist_req_type rq;
      int unsigned pick, sel, b;
      b = axis_log2();
      rq = make_row(CMD_PIXEL, pixel_value(), pixel_value(),
                    READ_INDEX_W'($urandom_range(0, STORE_BINS - 1)), 1'b0, '0);
      pick = $urandom_range(0, 199);
      if (pick < 2) begin
         rq.cmd = CMD_START;
      end else if (pick < 8) begin
         rq.cmd = CMD_FINISH;
      end else if (pick < 68) begin
         rq.cmd = CMD_READ;
         sel = $urandom_range(0, 9);
         if (sel < 4) rq.index = READ_INDEX_W'(last_bin);
         else if (sel < 7) rq.index = READ_INDEX_W'($urandom_range(0, (1 << (2 * b)) - 1));
      end
      return rq;
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.bins_log2   = LOG2_W'($urandom_range(0, 7));
      c.bg_weight   = DIVISOR_W'($urandom_range(0, 255));
      c.img_width   = POS_W'($urandom_range(0, 20));
      c.img_height  = POS_W'($urandom_range(0, 20));
      c.win_start_x = POS_W'($urandom_range(0, 12));
      c.win_end_x   = ($urandom_range(0, 2) == 0) ? '0 : POS_W'($urandom_range(0, 20));
      c.win_start_y = POS_W'($urandom_range(0, 12));
      c.win_end_y   = ($urandom_range(0, 2) == 0) ? '0 : POS_W'($urandom_range(0, 20));
      return c;
   endfunction

   task automatic send_request(input hist_req_type rq);
      bit gives;
      logic [COUNT_W-1:0] cnt;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, max_gap);
         repeat (gap) begin
            @(negedge clock);
            push <= 1'b0;
            @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      @(negedge clock);
      push             <= 1'b1;
      req_cmd          <= rq.cmd;
      req_target_pixel <= rq.target;
      req_render_pixel <= rq.render;
      req_bin_index    <= rq.index;
      do @(posedge clock); while (full);
      histogram_step(rq, gives, cnt);
      if (gives) pending_counts.push_back(rq.known ? rq.count : cnt);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      valid     <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!ready);
      histogram_config(idx, data);
   endtask

   task automatic load_config(input cfg_type c);
      write_csr(REG_BINS_LOG2,   CSR_DATA_W'(c.bins_log2));
      write_csr(REG_BG_WEIGHT,   CSR_DATA_W'(c.bg_weight));
      write_csr(REG_IMG_WIDTH,   c.img_width);
      write_csr(REG_IMG_HEIGHT,  c.img_height);
      write_csr(REG_WIN_START_X, c.win_start_x);
      write_csr(REG_WIN_END_X,   c.win_end_x);
      write_csr(REG_WIN_START_Y, c.win_start_y);
      write_csr(REG_WIN_END_Y,   c.win_end_y);
      @(negedge clock);
      valid <= 1'b0;
   endtask

   // the last request of a phase is a read, so its answer means the block is idle
   task automatic settle();
      @(negedge clock);
      push <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // receiver: pop runs with stalls of varying length
   initial begin : drain
      int run;
      forever begin
         run = $urandom_range(1, 24);
         repeat (run) begin
            @(negedge clock);
            pop <= 1'b1;
         end
         case ($urandom_range(0, 7))
            0, 1:    run = 0;
            2:       run = 40;
            default: run = $urandom_range(1, 14);
         endcase
         repeat (run) begin
            @(negedge clock);
            pop <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_counts.size() == 0) begin
            report_mismatch("result with no read waiting", rsp_bin_count, '0);
         end else if (rsp_bin_count !== pending_counts[0]) begin
            report_mismatch("bin count", rsp_bin_count, pending_counts.pop_front());
         end else begin
            void'(pending_counts.pop_front());
         end
      end
   end

   initial begin : stimulus
      cfg_type phase_cfgs [$];
      int waited;
      histogram_reset();

      // defaults after reset: 32 bins per axis, full 640x480 window
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'd0,    1'b1, 26'd0));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'hFFF,  1'b1, 26'd0));
      directed_rows.push_back(make_row(CMD_PIXEL,  8'h00, 8'h00, 12'd0,    1'b0, '0));
      directed_rows.push_back(make_row(CMD_PIXEL,  8'hFF, 8'hFF, 12'hFFF,  1'b0, '0));
      directed_rows.push_back(make_row(CMD_PIXEL,  8'hFF, 8'h00, 12'd0,    1'b0, '0));
      directed_rows.push_back(make_row(CMD_PIXEL,  8'h00, 8'hFF, 12'd0,    1'b0, '0));
      directed_rows.push_back(make_row(CMD_PIXEL,  8'h00, 8'h00, 12'd0,    1'b0, '0));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'd0,    1'b1, 26'd4));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'd1023, 1'b1, 26'd2));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'd31,   1'b1, 26'd2));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'd992,  1'b1, 26'd2));
      directed_rows.push_back(make_row(CMD_PIXEL,  8'hAA, 8'h55, 12'd0,    1'b0, '0));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'd341,  1'b0, '0));
      directed_rows.push_back(make_row(CMD_FINISH, 8'h00, 8'h00, 12'd0,    1'b0, '0));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'd0,    1'b1, 26'd4));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'd31,   1'b1, 26'd2));
      directed_rows.push_back(make_row(CMD_START,  8'h00, 8'h00, 12'd0,    1'b0, '0));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'd1023, 1'b1, 26'd0));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'd0,    1'b1, 26'd0));
      directed_rows.push_back(make_row(CMD_PIXEL,  8'h5A, 8'hA5, 12'd0,    1'b0, '0));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'hAAA,  1'b0, '0));
      directed_rows.push_back(make_row(CMD_READ,   8'h00, 8'h00, 12'h555,  1'b0, '0));

      // bins, weight, width, height, window start x, end x, start y, end y
      phase_cfgs.push_back('{3'd6, 8'd0,   13'd16,   13'd12,   13'd0,    13'd0,    13'd0,    13'd0});
      phase_cfgs.push_back('{3'd1, 8'd255, 13'd8,    13'd8,    13'd2,    13'd6,    13'd1,    13'd5});
      phase_cfgs.push_back('{3'd0, 8'd3,   13'd5,    13'd4,    13'd0,    13'd0,    13'd0,    13'd0});
      phase_cfgs.push_back('{3'd7, 8'd2,   13'd1,    13'd20,   13'd0,    13'd0,    13'd3,    13'd0});
      // zero width: the row counter climbs every pixel, only rows 20 to 49 count
      phase_cfgs.push_back('{3'd3, 8'd7,   13'd0,    13'd8191, 13'd0,    13'd1,    13'd20,   13'd50});
      phase_cfgs.push_back('{3'd4, 8'd1,   13'd8191, 13'd8191, 13'd8190, 13'd8191, 13'd0,    13'd0});
      phase_cfgs.push_back('{3'd2, 8'd128, 13'd12,   13'd10,   13'd5,    13'd3,    13'd0,    13'd0});
      phase_cfgs.push_back('{3'd5, 8'd1,   13'd640,  13'd480,  13'd0,    13'd0,    13'd0,    13'd0});
      phase_cfgs.push_back('{3'd6, 8'd255, 13'd4096, 13'd4096, 13'd0,    13'd4096, 13'd0,    13'd4096});
      repeat (4) phase_cfgs.push_back(random_cfg());

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);
      settle();

      foreach (phase_cfgs[p]) begin
         load_config(phase_cfgs[p]);
         max_gap = (p % 3 == 2 || p == SWEEP_PHASE) ? 0 : $urandom_range(1, 6);
         burst_left = 0;
         send_request(make_row(CMD_START, 8'h00, 8'h00, 12'd0, 1'b0, '0));
         if (p == SWEEP_PHASE) begin
            repeat (SWEEP_PIXELS) begin
               send_request(make_row(CMD_PIXEL, pixel_value(), pixel_value(), 12'd0, 1'b0, '0));
            end
            for (int i = 0; i < 64; i++) begin
               send_request(make_row(CMD_READ, 8'h00, 8'h00, READ_INDEX_W'(i), 1'b0, '0));
            end
         end
         repeat (PHASE_ITEMS) send_request(random_request());
         send_request(make_row(CMD_READ, 8'h00, 8'h00,
                               READ_INDEX_W'($urandom_range(0, STORE_BINS - 1)), 1'b0, '0));
         settle();
      end

      waited = 0;
      while (pending_counts.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
      while (pending_counts.size() != 0) begin
         report_mismatch("read never answered", '0, pending_counts.pop_front());
      end

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/jih_pkg.sv
src/jih_front.sv
src/jih_opq.sv
src/jih_div.sv
src/jih_back.sv
src/joint_intensity_histogram_unit.sv
tb/testbench.sv
